// File: sv/cursor_list_engine_defines.svh
// Assertion macros for the cursor list engine checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef CURSOR_LIST_ENGINE_DEFINES_SVH
`define CURSOR_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CLE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cursor list engine check failed");

// next-cycle implication, disabled during reset
`define CLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cursor list engine check failed");

`endif

// File: sv/cle_pkg.sv
// Shared command and status codes and control structs for the cursor list engine.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

  localparam int CMD_WIDTH    = 3;
  localparam int STATUS_WIDTH = 2;

  localparam logic [CMD_WIDTH-1:0] CMD_START   = 3'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_ADVANCE = 3'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_INSERT  = 3'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_ATTACH  = 3'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_REMOVE  = 3'd4;
  localparam logic [CMD_WIDTH-1:0] CMD_READ    = 3'd5;

  localparam logic [STATUS_WIDTH-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL       = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_NO_CURRENT = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic value_we;
    logic next_we;
  } mem_ctl_t;

  typedef struct packed {
    logic                    done;
    logic                    has_current;
    logic [STATUS_WIDTH-1:0] status;
  } rsp_ctl_t;

endpackage

`default_nettype wire

// File: sv/cle_cmd_if.sv
// Command channel: valid/ready handshake carrying one command word.
// Depends on cle_pkg for the command width.
`timescale 1ns / 1ps
`default_nettype none

interface cle_cmd_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [cle_pkg::CMD_WIDTH-1:0] cmd;
  logic [VALUE_WIDTH-1:0]       entry_value;

  modport source (output valid, output cmd, output entry_value, input ready);
  modport sink   (input valid, input cmd, input entry_value, output ready);
endinterface

`default_nettype wire

// File: sv/cle_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on cle_pkg for the status width.
`timescale 1ns / 1ps
`default_nettype none

interface cle_rsp_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 9
);
  logic                             valid;
  logic                             ready;
  logic [VALUE_WIDTH-1:0]           current_value;
  logic                             has_current;
  logic [COUNT_WIDTH-1:0]           item_count;
  logic [cle_pkg::STATUS_WIDTH-1:0] status;

  modport source (output valid, output current_value, output has_current,
                  output item_count, output status, input ready);
  modport sink   (input valid, input current_value, input has_current,
                  input item_count, input status, output ready);
endinterface

`default_nettype wire

// File: sv/cursor_list_engine.sv
// A result word is registered from the execute state and then goes valid.
// No new command is taken while the last is in its execute state, where its node
// memory read returns and its second link write runs, or while a result is stalled.
// Reset: synchronous; empties the list and clears the cursor.
// The free chain is implied by a fresh-node mark, so no clearing pass runs.
// Top level; depends on cle_pkg, cle_cmd_if, cle_rsp_if, cle_node_mem and cle_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module cursor_list_engine #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  wire        clk,
  input  wire        rst,
  cle_cmd_if.sink    req,
  cle_rsp_if.source  rsp
);
  import cle_pkg::*;

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  mem_ctl_t               mem_ctl;
  logic [AW-1:0]          mem_raddr;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wvalue;
  logic [IW-1:0]          mem_wnext;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic [IW-1:0]          rd_next;
  rsp_ctl_t               rsp_ctl;
  logic [VALUE_WIDTH-1:0] rsp_value;
  logic [IW-1:0]          rsp_count;
  logic                   out_free;

  logic                    out_valid;
  logic [VALUE_WIDTH-1:0]  out_value;
  logic                    out_has;
  logic [IW-1:0]           out_count;
  logic [STATUS_WIDTH-1:0] out_status;

  assign out_free = !out_valid || rsp.ready;

  cle_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IW          (IW),
    .AW          (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_cmd     (req.cmd),
    .in_value   (req.entry_value),
    .out_free   (out_free),
    .mem_ctl    (mem_ctl),
    .mem_raddr  (mem_raddr),
    .mem_waddr  (mem_waddr),
    .mem_wvalue (mem_wvalue),
    .mem_wnext  (mem_wnext),
    .rd_value   (rd_value),
    .rd_next    (rd_next),
    .rsp_ctl    (rsp_ctl),
    .rsp_value  (rsp_value),
    .rsp_count  (rsp_count)
  );

  cle_node_mem #(
    .DEPTH       (CAPACITY),
    .AW          (AW),
    .IW          (IW),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk      (clk),
    .ctl      (mem_ctl),
    .raddr    (mem_raddr),
    .waddr    (mem_waddr),
    .wvalue   (mem_wvalue),
    .wnext    (mem_wnext),
    .rd_value (rd_value),
    .rd_next  (rd_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_ctl.done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ctl.done) begin
      out_value  <= rsp_value;
      out_has    <= rsp_ctl.has_current;
      out_count  <= rsp_count;
      out_status <= rsp_ctl.status;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.current_value = out_value;
  assign rsp.has_current   = out_has;
  assign rsp.item_count    = out_count;
  assign rsp.status        = out_status;

endmodule

`default_nettype wire

// File: sv/cle_node_mem.sv
// Node store: value and link memories, one write port each, shared registered read.
// Depends on cle_pkg for the memory control struct.
`timescale 1ns / 1ps
`default_nettype none

module cle_node_mem #(
  parameter int DEPTH       = 256,
  parameter int AW          = 8,
  parameter int IW          = 9,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                    clk,
  input  cle_pkg::mem_ctl_t      ctl,
  input  wire  [AW-1:0]          raddr,
  input  wire  [AW-1:0]          waddr,
  input  wire  [VALUE_WIDTH-1:0] wvalue,
  input  wire  [IW-1:0]          wnext,
  output logic [VALUE_WIDTH-1:0] rd_value,
  output logic [IW-1:0]          rd_next
);
  import cle_pkg::*;

  logic [VALUE_WIDTH-1:0] value_mem [DEPTH];
  logic [IW-1:0]          next_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_value <= value_mem[raddr];
    end
    if (ctl.value_we) begin
      value_mem[waddr] <= wvalue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_next <= next_mem[raddr];
    end
    if (ctl.next_we) begin
      next_mem[waddr] <= wnext;
    end
  end

endmodule

`default_nettype wire

// File: sv/cle_ctrl.sv
// Command sequencer: list pointers, cursor cache, free list and fresh-node mark.
// Depends on cle_pkg; drives cle_node_mem.
`timescale 1ns / 1ps
`default_nettype none

module cle_ctrl #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32,
  parameter int IW          = 9,
  parameter int AW          = 8
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [cle_pkg::CMD_WIDTH-1:0] in_cmd,
  input  wire  [VALUE_WIDTH-1:0]        in_value,
  input  wire                           out_free,
  output cle_pkg::mem_ctl_t             mem_ctl,
  output logic [AW-1:0]                 mem_raddr,
  output logic [AW-1:0]                 mem_waddr,
  output logic [VALUE_WIDTH-1:0]        mem_wvalue,
  output logic [IW-1:0]                 mem_wnext,
  input  wire  [VALUE_WIDTH-1:0]        rd_value,
  input  wire  [IW-1:0]                 rd_next,
  output cle_pkg::rsp_ctl_t             rsp_ctl,
  output logic [VALUE_WIDTH-1:0]        rsp_value,
  output logic [IW-1:0]                 rsp_count
);
  import cle_pkg::*;

  localparam logic [IW-1:0] NIL       = IW'(CAPACITY);
  localparam logic [IW-1:0] CAP_COUNT = IW'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                   state, state_next;
  logic [CMD_WIDTH-1:0]   cmd;
  logic [VALUE_WIDTH-1:0] value;

  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [IW-1:0] cursor, cursor_next;
  logic [IW-1:0] prev, prev_next;
  logic [IW-1:0] free_head, free_head_next;
  logic [IW-1:0] fresh, fresh_next;
  logic [IW-1:0] count, count_next;
  logic [IW-1:0] cur_next, cur_next_next;
  logic [VALUE_WIDTH-1:0] cur_value, cur_value_next;

  logic                    accept;
  logic                    have;
  logic                    full;
  logic                    take_fresh;
  logic [IW-1:0]           rd_idx;
  logic [IW-1:0]           wr_idx;
  logic [STATUS_WIDTH-1:0] status;

  assign in_ready   = (state == S_IDLE) && out_free;
  assign accept     = in_valid && in_ready;
  assign have       = (cursor != NIL);
  assign full       = (count == CAP_COUNT) || (free_head == NIL);
  assign take_fresh = (free_head == fresh);
  assign mem_raddr  = rd_idx[AW-1:0];
  assign mem_waddr  = wr_idx[AW-1:0];

  // read and first write in the accept cycle, dependent link write in the next
  always_comb begin
    mem_ctl    = '0;
    rd_idx     = cur_next;
    wr_idx     = cursor;
    mem_wvalue = in_value;
    mem_wnext  = NIL;
    if (accept) begin
      unique case (in_cmd)
        CMD_START: begin
          mem_ctl.rd_en = (head != NIL);
          rd_idx        = head;
        end
        CMD_ADVANCE: begin
          mem_ctl.rd_en = have && (cur_next != NIL);
        end
        CMD_INSERT: begin
          mem_ctl.rd_en    = !full;
          mem_ctl.value_we = !full;
          mem_ctl.next_we  = !full;
          rd_idx           = free_head;
          wr_idx           = free_head;
          mem_wnext        = have ? cursor : head;
        end
        CMD_ATTACH: begin
          mem_ctl.rd_en    = !full;
          mem_ctl.value_we = !full;
          mem_ctl.next_we  = !full;
          rd_idx           = free_head;
          wr_idx           = free_head;
          mem_wnext        = have ? cur_next : NIL;
        end
        CMD_REMOVE: begin
          mem_ctl.rd_en   = have && (cur_next != NIL);
          mem_ctl.next_we = have;
          mem_wnext       = free_head;
        end
        default: begin
        end
      endcase
    end else if (state == S_EXEC) begin
      mem_wnext = free_head;
      unique case (cmd)
        CMD_INSERT: begin
          mem_ctl.next_we = !full && have && (prev != NIL);
          wr_idx          = prev;
        end
        CMD_ATTACH: begin
          mem_ctl.next_we = !full && (have || (tail != NIL));
          wr_idx          = have ? cursor : tail;
        end
        CMD_REMOVE: begin
          mem_ctl.next_we = have && (cursor != head);
          wr_idx          = prev;
          mem_wnext       = cur_next;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    cursor_next    = cursor;
    prev_next      = prev;
    free_head_next = free_head;
    fresh_next     = fresh;
    count_next     = count;
    cur_next_next  = cur_next;
    cur_value_next = cur_value;
    status         = ST_OK;
    if (accept) begin
      state_next = S_EXEC;
    end
    if (state == S_EXEC) begin
      state_next = S_IDLE;
      unique case (cmd)
        CMD_START: begin
          cursor_next    = head;
          prev_next      = NIL;
          cur_value_next = rd_value;
          cur_next_next  = rd_next;
        end
        CMD_ADVANCE: begin
          if (!have) begin
            status = ST_NO_CURRENT;
          end else begin
            prev_next      = cursor;
            cursor_next    = cur_next;
            cur_value_next = rd_value;
            cur_next_next  = rd_next;
          end
        end
        CMD_INSERT: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            free_head_next = take_fresh ? IW'(free_head + 1'b1) : rd_next;
            fresh_next     = take_fresh ? IW'(fresh + 1'b1) : fresh;
            if (!have) begin
              if (count == '0) begin
                tail_next = free_head;
              end
              head_next     = free_head;
              prev_next     = NIL;
              cur_next_next = head;
            end else begin
              if (prev == NIL) begin
                head_next = free_head;
              end
              cur_next_next = cursor;
            end
            cursor_next    = free_head;
            cur_value_next = value;
            count_next     = IW'(count + 1'b1);
          end
        end
        CMD_ATTACH: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            free_head_next = take_fresh ? IW'(free_head + 1'b1) : rd_next;
            fresh_next     = take_fresh ? IW'(fresh + 1'b1) : fresh;
            if (!have) begin
              if (tail != NIL) begin
                prev_next = tail;
              end else begin
                head_next = free_head;
                prev_next = NIL;
              end
              tail_next     = free_head;
              cur_next_next = NIL;
            end else begin
              if (cursor == tail) begin
                tail_next = free_head;
              end
              prev_next = cursor;
            end
            cursor_next    = free_head;
            cur_value_next = value;
            count_next     = IW'(count + 1'b1);
          end
        end
        CMD_REMOVE: begin
          if (!have) begin
            status = ST_NO_CURRENT;
          end else begin
            if (cursor == head) begin
              head_next = cur_next;
              prev_next = NIL;
              if (cur_next == NIL) begin
                tail_next = NIL;
              end
            end else if (cursor == tail) begin
              tail_next = prev;
            end
            cursor_next    = cur_next;
            cur_value_next = rd_value;
            cur_next_next  = rd_next;
            free_head_next = cursor;
            if (count != '0) begin
              count_next = IW'(count - 1'b1);
            end
          end
        end
        CMD_READ: begin
          if (!have) begin
            status = ST_NO_CURRENT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rsp_ctl.done        = (state == S_EXEC);
    rsp_ctl.has_current = (cursor_next != NIL);
    rsp_ctl.status      = status;
    rsp_value           = (cursor_next != NIL) ? cur_value_next : '0;
    rsp_count           = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NIL;
      tail      <= NIL;
      cursor    <= NIL;
      prev      <= NIL;
      free_head <= '0;
      fresh     <= '0;
      count     <= '0;
      cur_next  <= NIL;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      cursor    <= cursor_next;
      prev      <= prev_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      count     <= count_next;
      cur_next  <= cur_next_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_value <= cur_value_next;
    if (accept) begin
      cmd   <= in_cmd;
      value <= in_value;
    end
  end

endmodule

`default_nettype wire

// File: sv/cle_chk.sv
// Port-level checker for the cursor list engine, bound to the top level.
// Depends on cle_pkg and cursor_list_engine_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "cursor_list_engine_defines.svh"

module cle_chk #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input wire                              clk,
  input wire                              rst,
  input wire                              req_valid,
  input wire                              req_ready,
  input wire                              rsp_valid,
  input wire                              rsp_ready,
  input wire [VALUE_WIDTH-1:0]            rsp_current_value,
  input wire                              rsp_has_current,
  input wire [$clog2(CAPACITY + 1)-1:0]   rsp_item_count,
  input wire [cle_pkg::STATUS_WIDTH-1:0]  rsp_status
);
  import cle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic                                 req_accept;
  logic                                 rsp_stalled;
  logic [VALUE_WIDTH+CW+STATUS_WIDTH:0] rsp_word;

  assign req_accept  = req_valid && req_ready;
  assign rsp_stalled = rsp_valid && !rsp_ready;
  assign rsp_word    = {rsp_current_value, rsp_has_current, rsp_item_count, rsp_status};

  `CLE_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_accept, !req_ready)
  `CLE_ASSERT_NEXT(a_result_two_cycles, clk, rst, req_accept, ##1 rsp_valid)
  `CLE_ASSERT_NEXT(a_result_holds, clk, rst, rsp_stalled, rsp_valid && $stable(rsp_word))
  `CLE_ASSERT_NOW(a_full_means_capacity, clk, rst, rsp_valid && (rsp_status == ST_FULL), rsp_item_count == CW'(CAPACITY))

endmodule

bind cursor_list_engine cle_chk #(
  .CAPACITY    (CAPACITY),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_cle_chk (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_current_value (rsp.current_value),
  .rsp_has_current   (rsp.has_current),
  .rsp_item_count    (rsp.item_count),
  .rsp_status        (rsp.status)
);

`default_nettype wire
